### hdl/gbk_pkg.sv
// Shared types and constants for the 5x5 Gaussian blur unit.
// No dependencies.
package gbk_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

    localparam int KW_W   = 6;
    localparam int ROW_W  = 15;
    localparam int SUM_W  = 17;
    localparam int RCP_W  = 17;
    localparam int RCP_SH = 25;
    // floor(x/273) == (x * 122911) >> 25 for all x < 123817 (max sum is 255*273)
    localparam logic [RCP_W-1:0] RECIP_273 = 17'd122911;

    localparam logic [KW_W-1:0] KERNEL [25] = '{
        6'd1, 6'd4,  6'd7,  6'd4,  6'd1,
        6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
        6'd7, 6'd26, 6'd41, 6'd26, 6'd7,
        6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
        6'd1, 6'd4,  6'd7,  6'd4,  6'd1
    };

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
    } gbk_mask_t;

endpackage

### hdl/gbk_if.sv
// Channel interfaces: pixel input, blurred result, register write.
// Depends on gbk_pkg.
interface gbk_pix_if;
    logic                       valid;
    logic                       ready;
    logic [gbk_pkg::PIX_W-1:0]  pixel_red;
    logic [gbk_pkg::PIX_W-1:0]  pixel_green;
    logic [gbk_pkg::PIX_W-1:0]  pixel_blue;
    modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface gbk_res_if;
    logic                       valid;
    logic                       ready;
    logic [gbk_pkg::PIX_W-1:0]  out_red;
    logic [gbk_pkg::PIX_W-1:0]  out_green;
    logic [gbk_pkg::PIX_W-1:0]  out_blue;
    logic                       last_of_frame;
    modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

interface gbk_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gbk_pkg::CFG_IDX_W-1:0]   index;
    logic [gbk_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/gaussian_blur_5x5_unit.sv
// Top level of the 5x5 Gaussian blur: counters, line store, window, three lanes.
// Depends on gbk_pkg, gbk_if and gbk_lane.
//
//  channel  | modport | payload
//  pixels   | sink    | pixel_red, pixel_green, pixel_blue
//  blurred  | source  | out_red, out_green, out_blue, last_of_frame
//  cfg      | sink    | index, data (always ready)
//
// One pixel item per clock while blurred is not stalled; an item passes the s1, s2, s3 and output registers.
// The line store is one 96-bit wide RAM read and written once per item.
// rst_n clears counters and valid bits and sets width and height to 1024, then a pass
// over all MAX_WIDTH+2 entries (1026 by default) zeroes the line store with pixels.ready low.
// A stall at blurred holds the whole pipeline and drops pixels.ready.
module gaussian_blur_5x5_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    gbk_pix_if.sink   pixels,
    gbk_res_if.source blurred,
    gbk_cfg_if.sink   cfg
);

    localparam int CW       = $clog2(MAX_WIDTH + 2);
    localparam int RW       = $clog2(MAX_HEIGHT + 2);
    localparam int WW       = (CW > gbk_pkg::WIDTH_W) ? CW : gbk_pkg::WIDTH_W;
    localparam int HW       = (RW > gbk_pkg::HEIGHT_W) ? RW : gbk_pkg::HEIGHT_W;
    localparam int LS_DEPTH = MAX_WIDTH + 2;

    logic [gbk_pkg::WIDTH_W-1:0]  width_reg;
    logic [gbk_pkg::HEIGHT_W-1:0] height_reg;
    logic [WW-1:0] w_wide;
    logic [HW-1:0] h_wide;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    logic [CW-1:0] col_reg, col_next, c_eff;
    logic [RW-1:0] row_reg, row_next, r_eff;
    logic          accept, en;
    logic [gbk_pkg::RGB_W-1:0] cur;

    logic          clearing_reg;
    logic [CW-1:0] clr_reg;

    logic [4*gbk_pkg::RGB_W-1:0] line_mem [LS_DEPTH];
    logic [4*gbk_pkg::RGB_W-1:0] rdata_reg;

    logic                       s1_valid_reg;
    logic [CW-1:0]              s1_col_reg;
    logic [RW-1:0]              s1_row_reg;
    logic [gbk_pkg::RGB_W-1:0]  s1_cur_reg;
    logic [gbk_pkg::RGB_W-1:0]  window_reg [25];

    gbk_pkg::gbk_mask_t mask_next, s2_mask_reg;
    logic [CW:0]        cs;
    logic [RW:0]        rs;
    logic               emit, last;
    logic               s2_valid_reg, s2_last_reg;
    logic               s3_valid_reg, s3_last_reg;
    logic               out_valid_reg, out_last_reg;

    logic [24:0][gbk_pkg::PIX_W-1:0] red_px, green_px, blue_px;

    // effective dimensions
    always_comb
    begin
        w_wide = WW'(width_reg);
        h_wide = HW'(height_reg);
        if (w_wide == '0)
            w_eff = CW'(1);
        else if (w_wide > WW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(w_wide);
        if (h_wide == '0)
            h_eff = RW'(1);
        else if (h_wide > HW'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(h_wide);
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gbk_pkg::WIDTH_W'(1024);
            height_reg <= gbk_pkg::HEIGHT_W'(1024);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == gbk_pkg::CFG_IMAGE_WIDTH)
                width_reg <= cfg.data[gbk_pkg::WIDTH_W-1:0];
            else if (cfg.index == gbk_pkg::CFG_IMAGE_HEIGHT)
                height_reg <= cfg.data[gbk_pkg::HEIGHT_W-1:0];
        end
    end

    // line store clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_reg == CW'(LS_DEPTH - 1))
                clearing_reg <= 1'b0;
            clr_reg <= clr_reg + CW'(1);
        end
    end

    assign en           = !out_valid_reg || blurred.ready;
    assign pixels.ready = en && !clearing_reg;
    assign accept       = pixels.valid && en && !clearing_reg;

    // grid position
    always_comb
    begin
        c_eff = (col_reg > w_eff + CW'(1)) ? '0 : col_reg;
        r_eff = (row_reg > h_eff + RW'(1)) ? '0 : row_reg;
        if (c_eff < w_eff && r_eff < h_eff)
            cur = {pixels.pixel_red, pixels.pixel_green, pixels.pixel_blue};
        else
            cur = '0;
        if (c_eff == w_eff + CW'(1))
        begin
            col_next = '0;
            row_next = (r_eff == h_eff + RW'(1)) ? '0 : r_eff + RW'(1);
        end
        else
        begin
            col_next = c_eff + CW'(1);
            row_next = r_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg && emit;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // line store: rows oldest first, low word is row 0
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            line_mem[clr_reg] <= '0;
        else if (en)
        begin
            rdata_reg <= line_mem[c_eff];
            if (s1_valid_reg)
                line_mem[s1_col_reg] <= {s1_cur_reg, rdata_reg[4*gbk_pkg::RGB_W-1:gbk_pkg::RGB_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg   <= c_eff;
            s1_row_reg   <= r_eff;
            s1_cur_reg   <= cur;
            s2_mask_reg  <= mask_next;
            s2_last_reg  <= last;
            s3_last_reg  <= s2_last_reg;
            out_last_reg <= s3_last_reg;
            if (s1_valid_reg)
            begin
                for (int t = 0; t < 5; t++)
                begin
                    for (int s = 0; s < 4; s++)
                        window_reg[t*5+s] <= window_reg[t*5+s+1];
                    if (t < 4)
                        window_reg[t*5+4] <= rdata_reg[t*gbk_pkg::RGB_W +: gbk_pkg::RGB_W];
                    else
                        window_reg[t*5+4] <= s1_cur_reg;
                end
            end
        end
    end

    // window cell (t, s) is image (c-4+s, r-4+t)
    always_comb
    begin
        cs = '0;
        rs = '0;
        for (int s = 0; s < 5; s++)
        begin
            cs = {1'b0, s1_col_reg} + (CW+1)'(s);
            mask_next.col[s] = (cs >= (CW+1)'(4)) && (cs < {1'b0, w_eff} + (CW+1)'(4));
        end
        for (int t = 0; t < 5; t++)
        begin
            rs = {1'b0, s1_row_reg} + (RW+1)'(t);
            mask_next.row[t] = (rs >= (RW+1)'(4)) && (rs < {1'b0, h_eff} + (RW+1)'(4));
        end
        emit = (s1_col_reg >= CW'(2)) && (s1_row_reg >= RW'(2));
        last = (s1_col_reg == w_eff + CW'(1)) && (s1_row_reg == h_eff + RW'(1));
    end

    always_comb
    begin
        for (int i = 0; i < 25; i++)
        begin
            red_px[i]   = window_reg[i][23:16];
            green_px[i] = window_reg[i][15:8];
            blue_px[i]  = window_reg[i][7:0];
        end
    end

    gbk_lane u_lane_red (
        .clk  (clk),
        .en   (en),
        .px   (red_px),
        .mask (s2_mask_reg),
        .q    (blurred.out_red)
    );

    gbk_lane u_lane_green (
        .clk  (clk),
        .en   (en),
        .px   (green_px),
        .mask (s2_mask_reg),
        .q    (blurred.out_green)
    );

    gbk_lane u_lane_blue (
        .clk  (clk),
        .en   (en),
        .px   (blue_px),
        .mask (s2_mask_reg),
        .q    (blurred.out_blue)
    );

    assign blurred.valid         = out_valid_reg;
    assign blurred.last_of_frame = out_last_reg;

    a_s2_drop: assert property (@(posedge clk) disable iff (!rst_n)
        en && !s1_valid_reg |=> !s2_valid_reg)
        else $error("s2 valid without s1 item");

    a_s3_follow: assert property (@(posedge clk) disable iff (!rst_n)
        en && s2_valid_reg |=> s3_valid_reg)
        else $error("s2 item lost");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && c_eff == w_eff + CW'(1) |=> col_reg == '0)
        else $error("column did not wrap");

endmodule

### hdl/gbk_lane.sv
// One color lane: masked kernel row sums, then total and divide by 273.
// Depends on gbk_pkg.
module gbk_lane (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [24:0][gbk_pkg::PIX_W-1:0]      px,
    input  gbk_pkg::gbk_mask_t                   mask,
    output logic [gbk_pkg::PIX_W-1:0]            q
);

    logic [gbk_pkg::ROW_W-1:0]                 row_sum_next [5];
    logic [gbk_pkg::ROW_W-1:0]                 row_sum_reg  [5];
    logic [gbk_pkg::SUM_W-1:0]                 total;
    logic [gbk_pkg::SUM_W+gbk_pkg::RCP_W-1:0]  prod;
    logic [gbk_pkg::PIX_W-1:0]                 q_reg;

    always_comb
    begin
        for (int t = 0; t < 5; t++)
        begin
            row_sum_next[t] = '0;
            for (int s = 0; s < 5; s++)
            begin
                if (mask.row[t] && mask.col[s])
                begin
                    row_sum_next[t] = row_sum_next[t]
                        + gbk_pkg::ROW_W'(gbk_pkg::KERNEL[t*5+s])
                        * gbk_pkg::ROW_W'(px[t*5+s]);
                end
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int t = 0; t < 5; t++)
        begin
            total = total + gbk_pkg::SUM_W'(row_sum_reg[t]);
        end
        prod = (gbk_pkg::SUM_W+gbk_pkg::RCP_W)'(total) * gbk_pkg::RECIP_273;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_sum_reg <= row_sum_next;
            q_reg       <= prod[gbk_pkg::RCP_SH +: gbk_pkg::PIX_W];
        end
    end

    assign q = q_reg;

endmodule
